@@ design/ssc_pkg.sv @@
// shared types, constants and helper functions of the substring occurrence scanner
`default_nettype none

package ssc_pkg;

    localparam int NEEDLE_MAX_DEF = 32;
    localparam int TEXT_MAX       = 16777216;
    localparam int POS_W          = 25;
    localparam int START_W        = 24;
    localparam int CNT_W          = 25;
    localparam int LEN_W          = 6;
    localparam int CFG_W          = 64;
    localparam int CFG_IDX_W      = 3;
    localparam int NEEDLE_REGS    = 4;
    localparam int NEEDLE_BYTES   = 32;
    localparam int NB_IDX_W       = 5;
    localparam int RES_MAX        = 3;
    localparam int PUSH_W         = 2;
    localparam int OUT_DEPTH      = 8;
    localparam int OUT_PTR_W      = 3;
    localparam int OUT_LVL_W      = 4;

    typedef logic [7:0] t_byte;

    localparam t_byte CH_DIGIT_0 = 8'h30;
    localparam t_byte CH_DIGIT_9 = 8'h39;
    localparam t_byte CH_UPPER_A = 8'h41;
    localparam t_byte CH_UPPER_Z = 8'h5A;
    localparam t_byte CH_LOWER_A = 8'h61;
    localparam t_byte CH_LOWER_Z = 8'h7A;
    localparam t_byte CH_UNDER   = 8'h5F;
    localparam t_byte CASE_GAP   = 8'h20;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NEEDLE_0   = 3'd0,
        CFG_NEEDLE_1   = 3'd1,
        CFG_NEEDLE_2   = 3'd2,
        CFG_NEEDLE_3   = 3'd3,
        CFG_NEEDLE_LEN = 3'd4,
        CFG_WHOLE_WORD = 3'd5,
        CFG_EXACT_CASE = 3'd6
    } t_cfg_idx;

    localparam logic KIND_OCC = 1'b0;
    localparam logic KIND_SUM = 1'b1;

    typedef struct packed {
        logic eq_here;
        logic eq_prev;
        logic word;
    } t_cell_flags;

    typedef struct packed {
        logic               kind;
        logic [START_W-1:0] match_start;
        logic [POS_W-1:0]   match_end;
        logic [CNT_W-1:0]   match_count;
        logic               last;
    } t_res;

    function automatic t_byte fold(input t_byte c, input logic exact);
        t_byte r;
        r = c;
        if (!exact && c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
            r = c + CASE_GAP;
        end
        return r;
    endfunction

    function automatic logic is_word(input t_byte c);
        return (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) ||
               (c >= CH_UPPER_A && c <= CH_UPPER_Z) ||
               (c >= CH_LOWER_A && c <= CH_LOWER_Z) ||
               (c == CH_UNDER);
    endfunction

endpackage

`default_nettype wire

@@ design/ssc_cell.sv @@
// one window cell: holds a text byte and a needle byte, compares against both alignments
`default_nettype none

module ssc_cell (
    input  logic                  i_clk,
    input  logic                  i_shift,
    input  ssc_pkg::t_byte        i_byte_in,
    input  ssc_pkg::t_byte        i_need,
    input  ssc_pkg::t_byte        i_need_prev,
    input  logic                  i_exact_case,
    output ssc_pkg::t_byte        o_byte,
    output ssc_pkg::t_byte        o_need,
    output ssc_pkg::t_cell_flags  o_flags
);
    import ssc_pkg::*;

    t_byte r_byte;
    t_byte r_need;
    t_byte w_text;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte <= i_byte_in;
        end
        r_need <= i_need;
    end

    assign w_text          = fold(r_byte, i_exact_case);
    assign o_byte          = r_byte;
    assign o_need          = r_need;
    // eq_prev compares against the neighbor's needle byte: candidate ending one byte back
    assign o_flags.eq_here = (w_text == fold(r_need, i_exact_case));
    assign o_flags.eq_prev = (w_text == fold(i_need_prev, i_exact_case));
    assign o_flags.word    = is_word(r_byte);

endmodule

`default_nettype wire

@@ design/ssc_out_fifo.sv @@
// result queue: takes up to three items per cycle, hands out one per cycle while i_stall is low
`default_nettype none

module ssc_out_fifo (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ssc_pkg::t_res                 i_slot [ssc_pkg::RES_MAX],
    input  logic [ssc_pkg::PUSH_W-1:0]    i_push_n,
    output logic [ssc_pkg::OUT_LVL_W-1:0] o_level,
    output logic                          o_valid,
    input  logic                          i_stall,
    output ssc_pkg::t_res                 o_res
);
    import ssc_pkg::*;

    t_res                 r_mem [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] r_head;
    logic [OUT_PTR_W-1:0] r_tail;
    logic [OUT_LVL_W-1:0] r_level;
    logic                 w_pop;

    assign o_valid = (r_level != '0);
    assign w_pop   = o_valid && !i_stall;
    assign o_res   = r_mem[r_head];
    assign o_level = r_level;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < RES_MAX; i++) begin
            if (PUSH_W'(i) < i_push_n) begin
                r_mem[r_tail + OUT_PTR_W'(i)] <= i_slot[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_level <= '0;
        end else begin
            r_tail  <= r_tail + OUT_PTR_W'(i_push_n);
            r_head  <= r_head + OUT_PTR_W'(w_pop);
            r_level <= r_level + OUT_LVL_W'(i_push_n) - OUT_LVL_W'(w_pop);
        end
    end

endmodule

`default_nettype wire

@@ design/substring_occurrence_scanner.sv @@
// top level: config registers, window cell row, candidate decision and result queue
// Usage: text bytes enter on i_valid/o_stall with i_last_byte set on the final byte of a
// text; result items leave on o_valid/i_stall. An item is taken at a clock edge where
// valid is high and stall is low. Configuration is written through i_cfg_we,
// i_cfg_index and i_cfg_data while the block is idle.
// Throughput is one text byte per cycle while o_stall is low: the byte shifts into a row of
// window cells and both candidate alignments are compared across all cells in the following cycle.
// Results of a byte are written to the result queue at the edge after the byte is accepted,
// and leave the queue in order on o_valid.
// A byte gives at most one occurrence item; a final byte gives up to two occurrences
// plus the summary item, which leave one per cycle while i_stall is low through an eight-entry result queue.
// o_stall rises when that queue may not hold the results of the bytes in flight, so a
// stalled receiver holds o_valid and the result fields steady and back-pressures input;
// a final byte that queues three items can hold off the next input byte.
// Synchronous reset empties the queue, clears offsets and counts and restores the
// configuration defaults; no clearing pass is needed and bytes are taken right after.

`default_nettype none

module substring_occurrence_scanner #(
    parameter int NEEDLE_MAX = ssc_pkg::NEEDLE_MAX_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [7:0]                    i_text_byte,
    input  logic                          i_last_byte,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_kind,
    output logic [ssc_pkg::START_W-1:0]   o_match_start,
    output logic [ssc_pkg::POS_W-1:0]     o_match_end,
    output logic [ssc_pkg::CNT_W-1:0]     o_match_count,
    output logic                          o_last,
    input  logic                          i_cfg_we,
    input  logic [ssc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ssc_pkg::CFG_W-1:0]     i_cfg_data
);
    import ssc_pkg::*;

    localparam int WIN  = NEEDLE_MAX + 2;
    localparam int IW   = LEN_W + 1;
    localparam int SUMW = POS_W + 1;
    localparam logic [POS_W-1:0] TEXT_LIM = POS_W'(TEXT_MAX);

    // configuration
    logic [CFG_W-1:0] r_needle [NEEDLE_REGS];
    logic [LEN_W-1:0] r_len;
    logic             r_whole_word;
    logic             r_exact_case;

    // input side
    logic [POS_W-1:0] r_pos;
    logic             w_accept;
    logic             w_took;

    // decide stage
    logic             r_v1;
    logic             r_took;
    logic             r_fin;
    logic [POS_W-1:0] r_p;
    logic [POS_W-1:0] r_n;
    logic [POS_W-1:0] r_floor;
    logic [CNT_W-1:0] r_found;

    t_byte       w_needle [NEEDLE_BYTES];
    t_byte       w_cbyte  [WIN];
    t_byte       w_cneed  [WIN];
    t_cell_flags w_flags  [WIN];
    logic [WIN-1:0] w_eq_here;
    logic [WIN-1:0] w_eq_prev;
    logic [WIN-1:0] w_word;
    logic [WIN-1:0] w_mask1;
    logic [WIN-1:0] w_mask2;
    logic [WIN-1:0] w_lsel1;
    logic [WIN-1:0] w_lsel2;

    logic             w_usable;
    logic             w_m1;
    logic             w_m2;
    logic             w_wl1;
    logic             w_wl2;
    logic [SUMW-1:0]  w_lim1;
    logic [SUMW-1:0]  w_lim2;
    logic [POS_W-1:0] w_start1;
    logic [POS_W-1:0] w_start2;
    logic             w_acc1;
    logic             w_acc2;
    logic [CNT_W-1:0] w_found1;
    logic [CNT_W-1:0] w_found2;
    logic [POS_W-1:0] w_floor1;
    t_res             w_res1;
    t_res             w_res2;
    t_res             w_res_sum;
    t_res             w_slot [RES_MAX];
    logic [PUSH_W-1:0] w_push_n;

    logic [OUT_LVL_W-1:0] w_level;
    logic [OUT_LVL_W:0]   w_need_room;
    t_res                 w_out;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NEEDLE_REGS; i++) begin
                r_needle[i] <= '0;
            end
            r_len        <= '0;
            r_whole_word <= 1'b0;
            r_exact_case <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_NEEDLE_0:   r_needle[0]  <= i_cfg_data;
                CFG_NEEDLE_1:   r_needle[1]  <= i_cfg_data;
                CFG_NEEDLE_2:   r_needle[2]  <= i_cfg_data;
                CFG_NEEDLE_3:   r_needle[3]  <= i_cfg_data;
                CFG_NEEDLE_LEN: r_len        <= i_cfg_data[LEN_W-1:0];
                CFG_WHOLE_WORD: r_whole_word <= i_cfg_data[0];
                CFG_EXACT_CASE: r_exact_case <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    for (genvar k = 0; k < NEEDLE_BYTES; k++) begin : g_nb
        assign w_needle[k] = r_needle[k / 8][(k % 8) * 8 +: 8];
    end

    // room for the results of the byte in the decide stage and of a new one
    assign w_need_room = (OUT_LVL_W + 1)'(w_level) +
                         (r_v1 ? (OUT_LVL_W + 1)'(RES_MAX) : '0) +
                         (OUT_LVL_W + 1)'(RES_MAX);
    assign o_stall  = (w_need_room > (OUT_LVL_W + 1)'(OUT_DEPTH));
    assign w_accept = i_valid && !o_stall;
    assign w_took   = (r_pos < TEXT_LIM);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_v1  <= 1'b0;
        end else begin
            r_v1 <= w_accept;
            if (w_accept) begin
                if (i_last_byte) begin
                    r_pos <= '0;
                end else if (w_took) begin
                    r_pos <= r_pos + POS_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_took <= w_took;
            r_fin  <= i_last_byte;
            r_p    <= r_pos;
            r_n    <= w_took ? r_pos + POS_W'(1) : r_pos;
        end
    end

    // window cell row, newest byte in cell 0
    for (genvar j = 0; j < WIN; j++) begin : g_cell
        t_byte w_need_in;
        t_byte w_byte_in;
        t_byte w_need_prev;

        if (j < NEEDLE_MAX) begin : g_need
            logic [LEN_W-1:0] w_idx;
            assign w_idx     = r_len - LEN_W'(j + 1);
            assign w_need_in = w_needle[w_idx[NB_IDX_W-1:0]];
        end else begin : g_pad
            assign w_need_in = '0;
        end

        if (j == 0) begin : g_head
            assign w_byte_in   = i_text_byte;
            assign w_need_prev = '0;
        end else begin : g_link
            assign w_byte_in   = w_cbyte[j - 1];
            assign w_need_prev = w_cneed[j - 1];
        end

        ssc_cell u_cell (
            .i_clk        (i_clk),
            .i_shift      (w_accept && w_took),
            .i_byte_in    (w_byte_in),
            .i_need       (w_need_in),
            .i_need_prev  (w_need_prev),
            .i_exact_case (r_exact_case),
            .o_byte       (w_cbyte[j]),
            .o_need       (w_cneed[j]),
            .o_flags      (w_flags[j])
        );

        assign w_eq_here[j] = w_flags[j].eq_here;
        assign w_eq_prev[j] = w_flags[j].eq_prev;
        assign w_word[j]    = w_flags[j].word;
        // ending at newest byte: cells 0..len-1; ending one back: cells 1..len
        assign w_mask2[j]   = (IW'(j) < {1'b0, r_len});
        assign w_mask1[j]   = (j >= 1) && (IW'(j) <= {1'b0, r_len});
        assign w_lsel2[j]   = (IW'(j) == {1'b0, r_len});
        assign w_lsel1[j]   = (IW'(j) == {1'b0, r_len} + IW'(1));
    end

    assign w_usable = (r_len != '0) && (IW'(r_len) <= IW'(NEEDLE_MAX));
    assign w_m1     = &(w_eq_prev | ~w_mask1);
    assign w_m2     = &(w_eq_here | ~w_mask2);
    assign w_wl1    = |(w_word & w_lsel1);
    assign w_wl2    = |(w_word & w_lsel2);

    // candidate ending before the newest byte, right neighbor is the newest byte
    assign w_lim1   = SUMW'(r_floor) + SUMW'(r_len);
    assign w_start1 = r_p - POS_W'(r_len);
    assign w_acc1   = r_v1 && r_took && w_usable && (SUMW'(r_p) >= w_lim1) && w_m1 &&
                      (!r_whole_word ||
                       (((w_start1 == '0) || !w_wl1) && !w_word[0]));
    assign w_found1 = (w_acc1 && r_found < CNT_W'(TEXT_MAX)) ? r_found + CNT_W'(1) : r_found;
    assign w_floor1 = w_acc1 ? r_p : r_floor;

    // candidate ending at the final byte, text edge on the right
    assign w_lim2   = SUMW'(w_floor1) + SUMW'(r_len);
    assign w_start2 = r_n - POS_W'(r_len);
    assign w_acc2   = r_v1 && r_fin && w_usable && (SUMW'(r_n) >= w_lim2) && w_m2 &&
                      (!r_whole_word || (w_start2 == '0) || !w_wl2);
    assign w_found2 = (w_acc2 && w_found1 < CNT_W'(TEXT_MAX)) ?
                      w_found1 + CNT_W'(1) : w_found1;

    assign w_res1.kind        = KIND_OCC;
    assign w_res1.match_start = w_start1[START_W-1:0];
    assign w_res1.match_end   = r_p;
    assign w_res1.match_count = w_found1;
    assign w_res1.last        = 1'b0;

    assign w_res2.kind        = KIND_OCC;
    assign w_res2.match_start = w_start2[START_W-1:0];
    assign w_res2.match_end   = r_n;
    assign w_res2.match_count = w_found2;
    assign w_res2.last        = 1'b0;

    assign w_res_sum.kind        = KIND_SUM;
    assign w_res_sum.match_start = '0;
    assign w_res_sum.match_end   = r_n;
    assign w_res_sum.match_count = w_found2;
    assign w_res_sum.last        = 1'b1;

    // pack the item's results in order into consecutive queue slots
    always_comb begin
        logic [PUSH_W-1:0] k;
        k = '0;
        for (int i = 0; i < RES_MAX; i++) begin
            w_slot[i] = w_res_sum;
        end
        if (w_acc1) begin
            w_slot[k] = w_res1;
            k = k + PUSH_W'(1);
        end
        if (w_acc2) begin
            w_slot[k] = w_res2;
            k = k + PUSH_W'(1);
        end
        if (r_v1 && r_fin) begin
            w_slot[k] = w_res_sum;
            k = k + PUSH_W'(1);
        end
        w_push_n = k;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_floor <= '0;
            r_found <= '0;
        end else if (r_v1) begin
            if (r_fin) begin
                r_floor <= '0;
                r_found <= '0;
            end else begin
                r_floor <= w_floor1;
                r_found <= w_found1;
            end
        end
    end

    ssc_out_fifo u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_slot   (w_slot),
        .i_push_n (w_push_n),
        .o_level  (w_level),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_res    (w_out)
    );

    assign o_kind        = w_out.kind;
    assign o_match_start = w_out.match_start;
    assign o_match_end   = w_out.match_end;
    assign o_match_count = w_out.match_count;
    assign o_last        = w_out.last;

endmodule

`default_nettype wire
